// File: design/lfd_pkg.sv
package lfd_pkg;

    // Frame parser phases; unused codes fall back to header hunt
    typedef enum logic [2:0] {
        PH_HUNT  = 3'd0,
        PH_CMD   = 3'd1,
        PH_LEN   = 3'd2,
        PH_DATA  = 3'd3,
        PH_CHECK = 3'd4,
        PH_TAIL  = 3'd5
    } phase_t;

    // Result kinds
    localparam logic [1:0] KIND_PAYLOAD   = 2'd0;
    localparam logic [1:0] KIND_GOOD      = 2'd1;
    localparam logic [1:0] KIND_CHECK_ERR = 2'd2;
    localparam logic [1:0] KIND_TAIL_ERR  = 2'd3;

    // Configuration register indexes
    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned CFG_DATA_W  = 16;
    localparam logic [CFG_INDEX_W-1:0] CFG_HEADER_WORD = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_TAIL_VALUE  = 2'd1;

    // Register reset values
    localparam logic [15:0] HEADER_WORD_RST = 16'hAA55;
    localparam logic [7:0]  TAIL_VALUE_RST  = 8'h0D;

    // Parser state carried from byte to byte
    typedef struct packed {
        phase_t      phase;
        logic [7:0]  previous_byte;
        logic        have_previous;
        logic [7:0]  frame_command;
        logic [7:0]  frame_length;
        logic [7:0]  byte_count;
        logic [7:0]  running_sum;
        logic [7:0]  received_check;
    } parse_state_t;

    // One result transaction
    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  command;
        logic [7:0]  payload_length;
        logic [7:0]  payload_byte;
        logic [7:0]  payload_index;
        logic        frame_end;
    } result_t;

endpackage

// File: design/lfd_step.sv
module lfd_step
    import lfd_pkg::*;
(
    input  parse_state_t cur_state,
    input  logic [7:0]   rx_byte,
    input  logic [15:0]  header_word,
    input  logic [7:0]   tail_value,
    output parse_state_t next_state,
    output logic         emit,
    output result_t      result
);

    logic [7:0] sum_plus;
    logic [7:0] count_plus;

    assign sum_plus   = cur_state.running_sum + rx_byte;
    assign count_plus = cur_state.byte_count + 8'd1;

    // Per-byte phase update and result selection
    always_comb begin
        next_state             = cur_state;
        emit                   = 1'b0;
        result.kind            = KIND_PAYLOAD;
        result.command         = cur_state.frame_command;
        result.payload_length  = cur_state.frame_length;
        result.payload_byte    = 8'd0;
        result.payload_index   = 8'd0;
        result.frame_end       = 1'b0;

        case (cur_state.phase)
            PH_CMD: begin
                next_state.frame_command = rx_byte;
                next_state.running_sum   = rx_byte;
                next_state.phase         = PH_LEN;
            end
            PH_LEN: begin
                next_state.frame_length = rx_byte;
                next_state.running_sum  = sum_plus;
                next_state.byte_count   = 8'd0;
                next_state.phase        = (rx_byte == 8'd0) ? PH_CHECK : PH_DATA;
            end
            PH_DATA: begin
                emit                   = 1'b1;
                result.payload_byte    = rx_byte;
                result.payload_index   = cur_state.byte_count;
                next_state.running_sum = sum_plus;
                next_state.byte_count  = count_plus;
                if (count_plus == cur_state.frame_length) begin
                    next_state.phase = PH_CHECK;
                end
            end
            PH_CHECK: begin
                next_state.received_check = rx_byte;
                next_state.phase          = PH_TAIL;
            end
            PH_TAIL: begin
                emit             = 1'b1;
                result.frame_end = 1'b1;
                // tail mismatch takes precedence over checksum mismatch
                if (rx_byte != tail_value) begin
                    result.kind = KIND_TAIL_ERR;
                end else if (cur_state.received_check != cur_state.running_sum) begin
                    result.kind = KIND_CHECK_ERR;
                end else begin
                    result.kind = KIND_GOOD;
                end
                next_state.phase         = PH_HUNT;
                next_state.have_previous = 1'b0;
                next_state.previous_byte = 8'd0;
            end
            default: begin
                // header hunt: held byte against high byte, this byte against low
                if (cur_state.have_previous &&
                    cur_state.previous_byte == header_word[15:8] &&
                    rx_byte == header_word[7:0]) begin
                    next_state.phase         = PH_CMD;
                    next_state.have_previous = 1'b0;
                    next_state.previous_byte = 8'd0;
                end else begin
                    next_state.phase         = PH_HUNT;
                    next_state.previous_byte = rx_byte;
                    next_state.have_previous = 1'b1;
                end
            end
        endcase
    end

endmodule

// File: design/length_framed_deframer.sv
// Deframer for a header/command/length/payload/checksum/tail byte stream. One byte
// is taken per cycle while s_ready is high; the phase logic and 8-bit checksum add
// update the parser state, and results go to a single output register, so the block
// sustains one transaction per cycle. The input stalls only while that output
// register holds a result that m_ready has not taken. Payload bytes come out as
// kind 0; the tail byte yields one verdict transaction (good, checksum error, tail
// error) with m_frame_end set. Header and tail values are written through the cfg
// port and should only change while the block is idle.
module length_framed_deframer
    import lfd_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    // configuration
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    // byte stream in
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [7:0]             s_rx_byte,
    // results out
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [1:0]             m_kind,
    output logic [7:0]             m_command,
    output logic [7:0]             m_payload_length,
    output logic [7:0]             m_payload_byte,
    output logic [7:0]             m_payload_index,
    output logic                   m_frame_end
);

    logic [15:0]  header_word_reg;
    logic [7:0]   tail_value_reg;
    parse_state_t state_reg;
    parse_state_t state_next;
    logic         step_emit;
    result_t      step_result;
    result_t      result_reg;
    logic         m_valid_reg;
    logic         s_accept;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            header_word_reg <= HEADER_WORD_RST;
            tail_value_reg  <= TAIL_VALUE_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_HEADER_WORD: header_word_reg <= cfg_data;
                CFG_TAIL_VALUE:  tail_value_reg  <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    assign s_ready  = !m_valid_reg || m_ready;
    assign s_accept = s_valid && s_ready;

    lfd_step u_step (
        .cur_state   (state_reg),
        .rx_byte     (s_rx_byte),
        .header_word (header_word_reg),
        .tail_value  (tail_value_reg),
        .next_state  (state_next),
        .emit        (step_emit),
        .result      (step_result)
    );

    // Parser state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '{phase: PH_HUNT, default: '0};
        end else if (s_accept) begin
            state_reg <= state_next;
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_ready) begin
            m_valid_reg <= s_accept && step_emit;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept && step_emit) begin
            result_reg <= step_result;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_kind           = result_reg.kind;
    assign m_command        = result_reg.command;
    assign m_payload_length = result_reg.payload_length;
    assign m_payload_byte   = result_reg.payload_byte;
    assign m_payload_index  = result_reg.payload_index;
    assign m_frame_end      = result_reg.frame_end;

endmodule

// File: sim/tb.sv
`timescale 1ns / 100ps

module tb;
    import lfd_pkg::*;

    // Kinds of damage put into a generated frame
    typedef enum int {
        FLAW_NONE,
        FLAW_CHECK,
        FLAW_TAIL,
        FLAW_BOTH,
        FLAW_CUT
    } flaw_t;

    // Indexes past the last register; writes there must be ignored
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_HI = 2'd3;

    localparam int PHASE_BYTES = 170;
    localparam int HOLD_CYCLES = 400;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;
    logic                   s_valid   = 1'b0;
    logic                   s_ready;
    logic [7:0]             s_rx_byte = '0;
    logic                   m_valid;
    logic                   m_ready   = 1'b0;
    logic [1:0]             m_kind;
    logic [7:0]             m_command;
    logic [7:0]             m_payload_length;
    logic [7:0]             m_payload_byte;
    logic [7:0]             m_payload_index;
    logic                   m_frame_end;

    // Byte stream still to be offered, and deframer output still owed
    logic [7:0]   rx_stream[$];
    result_t      deframed_q[$];

    // Shadow of the parser and its registers
    parse_state_t parser;
    logic [15:0]  header_shadow;
    logic [7:0]   tail_shadow;

    // Current stimulus settings
    logic [15:0]  hdr_now  = HEADER_WORD_RST;
    logic [7:0]   tail_now = TAIL_VALUE_RST;
    int           frame_bytes;
    int           fault_count = 0;

    bit           no_idle    = 1'b0;
    bit           hold_armed = 1'b0;
    bit           hold_done  = 1'b0;
    int           stall_left = 0;

    result_t      want;
    result_t      got;
    result_t      predicted;

    length_framed_deframer dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_rx_byte        (s_rx_byte),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_kind           (m_kind),
        .m_command        (m_command),
        .m_payload_length (m_payload_length),
        .m_payload_byte   (m_payload_byte),
        .m_payload_index  (m_payload_index),
        .m_frame_end      (m_frame_end)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    // Advance the shadow parser by one byte; returns 1 when a result is due
    function automatic bit deframe_byte(input logic [7:0] b, output result_t res);
        res = '0;
        res.command        = parser.frame_command;
        res.payload_length = parser.frame_length;
        case (parser.phase)
            PH_CMD: begin
                parser.frame_command = b;
                parser.running_sum   = b;
                parser.phase         = PH_LEN;
                return 1'b0;
            end
            PH_LEN: begin
                parser.frame_length = b;
                parser.running_sum  = parser.running_sum + b;
                parser.byte_count   = '0;
                parser.phase        = (b == 8'd0) ? PH_CHECK : PH_DATA;
                return 1'b0;
            end
            PH_DATA: begin
                res.kind          = KIND_PAYLOAD;
                res.payload_byte  = b;
                res.payload_index = parser.byte_count;
                parser.running_sum = parser.running_sum + b;
                parser.byte_count  = parser.byte_count + 8'd1;
                if (parser.byte_count == parser.frame_length)
                    parser.phase = PH_CHECK;
                return 1'b1;
            end
            PH_CHECK: begin
                parser.received_check = b;
                parser.phase          = PH_TAIL;
                return 1'b0;
            end
            PH_TAIL: begin
                // tail is judged first, checksum only behind a good tail
                if (b != tail_shadow)
                    res.kind = KIND_TAIL_ERR;
                else if (parser.received_check != parser.running_sum)
                    res.kind = KIND_CHECK_ERR;
                else
                    res.kind = KIND_GOOD;
                res.frame_end        = 1'b1;
                parser.phase         = PH_HUNT;
                parser.have_previous = 1'b0;
                parser.previous_byte = '0;
                return 1'b1;
            end
            default: begin
                // hunt: each byte tried as header low byte against the one before
                if (parser.have_previous && parser.previous_byte == header_shadow[15:8]
                        && b == header_shadow[7:0]) begin
                    parser.phase         = PH_CMD;
                    parser.have_previous = 1'b0;
                    parser.previous_byte = '0;
                end else begin
                    parser.phase         = PH_HUNT;
                    parser.previous_byte = b;
                    parser.have_previous = 1'b1;
                end
                return 1'b0;
            end
        endcase
    endfunction

    // Sender: offers queued bytes, idling at random between transactions
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (rx_stream.size() != 0 && (no_idle || $urandom_range(0, 99) >= 37)) begin
                s_valid   <= 1'b1;
                s_rx_byte <= rx_stream.pop_front();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Receiver: random back-pressure plus one long hold-off
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (stall_left != 0) begin
            m_ready    <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (hold_armed && !hold_done && m_valid) begin
            m_ready    <= 1'b0;
            stall_left <= HOLD_CYCLES;
            hold_done  <= 1'b1;
        end else begin
            m_ready <= no_idle || ($urandom_range(0, 99) >= 37);
        end
    end

    // Monitor: predicts from accepted bytes, then checks accepted results
    always @(posedge aclk) begin
        if (!aresetn) begin
            parser        = '0;
            header_shadow = HEADER_WORD_RST;
            tail_shadow   = TAIL_VALUE_RST;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_HEADER_WORD: header_shadow = cfg_data;
                    CFG_TAIL_VALUE:  tail_shadow   = cfg_data[7:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                if (deframe_byte(s_rx_byte, predicted))
                    deframed_q.push_back(predicted);
            end
            if (m_valid && m_ready) begin
                got.kind           = m_kind;
                got.command        = m_command;
                got.payload_length = m_payload_length;
                got.payload_byte   = m_payload_byte;
                got.payload_index  = m_payload_index;
                got.frame_end      = m_frame_end;
                if (deframed_q.size() == 0) begin
                    fault_count++;
                    if (fault_count <= 10)
                        $display("unexpected: kind=%0d cmd=%02h len=%02h byte=%02h idx=%0d end=%0d",
                                 got.kind, got.command, got.payload_length,
                                 got.payload_byte, got.payload_index, got.frame_end);
                end else begin
                    want = deframed_q.pop_front();
                    if (got.kind !== want.kind || got.command !== want.command
                            || got.payload_length !== want.payload_length
                            || got.payload_byte !== want.payload_byte
                            || got.payload_index !== want.payload_index
                            || got.frame_end !== want.frame_end) begin
                        fault_count++;
                        if (fault_count <= 10) begin
                            $display("mismatch: want kind=%0d cmd=%02h len=%02h %02h/%0d end=%0d",
                                     want.kind, want.command, want.payload_length,
                                     want.payload_byte, want.payload_index, want.frame_end);
                            $display("          got  kind=%0d cmd=%02h len=%02h %02h/%0d end=%0d",
                                     got.kind, got.command, got.payload_length,
                                     got.payload_byte, got.payload_index, got.frame_end);
                        end
                    end
                end
            end
        end
    end

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // Wait until every byte is taken and every result has come, then settle
    task automatic wait_drained();
        do @(negedge aclk);
        while (rx_stream.size() != 0 || s_valid || deframed_q.size() != 0 || m_valid);
        repeat (4) @(negedge aclk);
    endtask

    // Build one frame with the current header and tail, optionally damaged
    task automatic queue_frame(input logic [7:0] cmd, input int len, input flaw_t flaw);
        logic [7:0] frame[$];
        logic [7:0] sum;
        logic [7:0] pb;
        logic [7:0] flip;
        int         i;
        int         keep;
        frame.push_back(hdr_now[15:8]);
        frame.push_back(hdr_now[7:0]);
        frame.push_back(cmd);
        frame.push_back(len[7:0]);
        sum = cmd + len[7:0];
        for (i = 0; i < len; i++) begin
            pb = 8'($urandom);
            frame.push_back(pb);
            sum = sum + pb;
        end
        flip = 8'($urandom_range(1, 255));
        if (flaw == FLAW_CHECK || flaw == FLAW_BOTH)
            sum = sum + flip;
        frame.push_back(sum);
        flip = 8'($urandom_range(1, 255));
        if (flaw == FLAW_TAIL || flaw == FLAW_BOTH)
            frame.push_back(tail_now ^ flip);
        else
            frame.push_back(tail_now);
        keep = (flaw == FLAW_CUT) ? $urandom_range(1, frame.size() - 1) : frame.size();
        for (i = 0; i < keep; i++)
            rx_stream.push_back(frame[i]);
        frame_bytes += keep;
    endtask

    // Stimulus
    initial begin
        int         ph;
        int         pick;
        int         len;
        int         n;
        flaw_t      flaw;
        logic [7:0] junk;

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: overlapping header start, zero length, verdict order
        frame_bytes = 0;
        rx_stream.push_back(hdr_now[15:8]);
        queue_frame(8'hFF, 0, FLAW_NONE);
        queue_frame(8'h00, 1, FLAW_BOTH);
        queue_frame(8'h5A, 2, FLAW_CHECK);
        queue_frame(8'hA5, 1, FLAW_TAIL);
        wait_drained();

        for (ph = 0; ph < 8; ph++) begin
            case (ph)
                0: begin hdr_now = 16'h0000; tail_now = 8'h00; end
                1: begin hdr_now = 16'hFFFF; tail_now = 8'hFF; end
                2: begin hdr_now = 16'h5A5A; tail_now = 8'($urandom); end
                3: begin hdr_now = 16'($urandom); tail_now = hdr_now[15:8]; end
                default: begin hdr_now = 16'($urandom); tail_now = 8'($urandom); end
            endcase
            junk = 8'($urandom);
            write_reg(CFG_HEADER_WORD, hdr_now);
            write_reg(CFG_TAIL_VALUE, {junk, tail_now});
            if (ph == 3 || ph == 6) begin
                write_reg(CFG_SPARE_LO, CFG_DATA_W'($urandom));
                write_reg(CFG_SPARE_HI, CFG_DATA_W'($urandom));
            end
            @(negedge aclk);
            no_idle    = (ph == 5);
            hold_armed = (ph == 2);
            frame_bytes = 0;

            // longest payload once
            if (ph == 1)
                queue_frame(8'($urandom), 255, FLAW_NONE);
            // tail equals header high byte: a closed frame must not seed a header
            if (ph == 3) begin
                queue_frame(8'($urandom), 0, FLAW_NONE);
                rx_stream.push_back(hdr_now[7:0]);
            end

            while (frame_bytes < PHASE_BYTES) begin
                pick = $urandom_range(0, 99);
                if (pick < 8) begin
                    n = $urandom_range(1, 4);
                    repeat (n) begin
                        if ($urandom_range(0, 3) == 0)
                            rx_stream.push_back(hdr_now[15:8]);
                        else
                            rx_stream.push_back(8'($urandom));
                    end
                end else begin
                    len  = ($urandom_range(0, 39) == 0) ? $urandom_range(0, 255)
                                                        : $urandom_range(0, 12);
                    flaw = (pick < 70) ? FLAW_NONE :
                           (pick < 80) ? FLAW_CHECK :
                           (pick < 87) ? FLAW_TAIL :
                           (pick < 92) ? FLAW_BOTH : FLAW_CUT;
                    queue_frame(8'($urandom), len, flaw);
                end
            end
            wait_drained();
        end

        if (fault_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // Watchdog
    initial begin
        #400000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// File: sim.f
design/lfd_pkg.sv
design/lfd_step.sv
design/length_framed_deframer.sv
sim/tb.sv
